### rtl/rmat_pkg.sv
// Shared constants and register codes of the R-MAT edge generator.
`timescale 1ns / 1ps
package rmat_pkg;

  // Twister geometry and constants
  localparam int unsigned TW_N = 312;
  localparam int unsigned TW_M = 156;
  localparam int unsigned TW_AW = $clog2(TW_N);
  localparam logic [63:0] TW_MATRIX   = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] TW_UPPER    = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] TW_LOWER    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] TW_INIT_MUL = 64'd6364136223846793005;

  // Tempering masks
  localparam logic [63:0] TMP_B = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TMP_C = 64'h71D6_7FFF_EEB4_4000;
  localparam logic [63:0] TMP_D = 64'hFFF7_EEE0_0000_0000;

  localparam int unsigned VTX_W = 63;
  localparam int unsigned CFG_IW = 3;
  localparam logic [5:0] SCALE_RESET = 6'd16;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_SEED_BASE = 3'd0,
    REG_SCALE     = 3'd1,
    REG_THR_A     = 3'd2,
    REG_THR_AB    = 3'd3,
    REG_THR_ABC   = 3'd4
  } reg_idx_e;

endpackage

### rtl/rmat_edge_generator.sv
// R-MAT edge generator: twister seeding, draws and quadrant selection.
`timescale 1ns / 1ps
// One R-MAT edge per item. An item is taken when start_i is high and busy_o
// is low. The twister is reseeded per item: TW_M + MAX_SCALE - 1 = 218 words,
// each in ST_MUL (the split 32x32 products) and then ST_ADD (sum and write
// the state memory), then ST_RD, ST_TEMP and ST_CMP per recursion level
// (memory read, twist and temper, threshold compare), then ST_DONE to order
// the endpoints. busy_o is high from the accepting edge until ST_DONE ends.
// The result is registered in ST_DONE and shown for exactly one cycle with
// done_o high and busy_o already low, so the next item can be taken at the
// edge that takes the result. The receiver cannot hold the result off and
// must take it then.
// Only the words that the first 63 draws touch are generated.
module rmat_edge_generator #(
  parameter int unsigned MAX_SCALE = 63
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [63:0]                     edge_index_i,
  input  logic                            cfg_we_i,
  input  logic [rmat_pkg::CFG_IW-1:0]     cfg_idx_i,
  input  logic [63:0]                     cfg_data_i,
  output logic                            done_o,
  output logic [rmat_pkg::VTX_W-1:0]      src_vertex_o,
  output logic [rmat_pkg::VTX_W-1:0]      dst_vertex_o,
  output logic                            edge_valid_o
);

  localparam int unsigned AW = rmat_pkg::TW_AW;
  localparam logic [AW-1:0] SEED_LAST = AW'(rmat_pkg::TW_M + MAX_SCALE - 1);
  localparam logic [AW-1:0] OFS_M = AW'(rmat_pkg::TW_M);
  localparam logic [5:0] MAX_LV = 6'(MAX_SCALE);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_RD, ST_TEMP, ST_CMP, ST_DONE
  } state_e;

  // Configuration registers
  logic [63:0] seed_base_q, thr_a_q, thr_ab_q, thr_abc_q;
  logic [5:0]  scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_base_q <= '0;
      scale_q     <= rmat_pkg::SCALE_RESET;
      thr_a_q     <= '0;
      thr_ab_q    <= '0;
      thr_abc_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rmat_pkg::REG_SEED_BASE: seed_base_q <= cfg_data_i;
        rmat_pkg::REG_SCALE:     scale_q     <= cfg_data_i[5:0];
        rmat_pkg::REG_THR_A:     thr_a_q     <= cfg_data_i;
        rmat_pkg::REG_THR_AB:    thr_ab_q    <= cfg_data_i;
        rmat_pkg::REG_THR_ABC:   thr_abc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Twister state memory
  logic [63:0] tw_mem [rmat_pkg::TW_N];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [63:0]   mem_wd;
  logic [AW-1:0] rd1_a, rd2_a;
  logic [63:0]   rd1_q, rd2_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) tw_mem[mem_wa] <= mem_wd;
    rd1_q <= tw_mem[rd1_a];
    rd2_q <= tw_mem[rd2_a];
  end

  state_e state_q;
  logic [63:0] prev_q, w0_q, p0_q, tmp_q;
  logic [31:0] p1_q, p2_q;
  logic [AW-1:0] idx_q;
  logic [5:0] lvl_q, levels_q;
  logic [rmat_pkg::VTX_W-1:0] src_q, dst_q;

  // Seeding arithmetic: low 64 bits of C * (p ^ (p >> 62)) + index from 32-bit parts
  logic [63:0] xw, seed_w, seed0;
  logic [31:0] cross_w;
  assign xw      = prev_q ^ (prev_q >> 62);
  assign cross_w = p1_q + p2_q;
  assign seed_w  = p0_q + {cross_w, 32'd0} + 64'(idx_q);
  assign seed0   = seed_base_q + edge_index_i;

  // Twist and temper one word
  logic [63:0] y, v, t1, t2, t3, t4;
  assign y  = (w0_q & rmat_pkg::TW_UPPER) | (rd1_q & rmat_pkg::TW_LOWER);
  assign v  = rd2_q ^ (y >> 1) ^ (y[0] ? rmat_pkg::TW_MATRIX : 64'd0);
  assign t1 = v  ^ ((v  >> 29) & rmat_pkg::TMP_B);
  assign t2 = t1 ^ ((t1 << 17) & rmat_pkg::TMP_C);
  assign t3 = t2 ^ ((t2 << 37) & rmat_pkg::TMP_D);
  assign t4 = t3 ^ (t3 >> 43);

  // Quadrant choice
  logic sb, db;
  always_comb begin
    if (tmp_q <= thr_a_q) begin
      sb = 1'b0; db = 1'b0;
    end else if (tmp_q <= thr_ab_q) begin
      sb = 1'b0; db = 1'b1;
    end else if (tmp_q <= thr_abc_q) begin
      sb = 1'b1; db = 1'b0;
    end else begin
      sb = 1'b1; db = 1'b1;
    end
  end

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = seed_w;
    if (state_q == ST_IDLE && start_i) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = seed0;
    end else if (state_q == ST_ADD) begin
      mem_we = 1'b1;
    end
    rd1_a = AW'(lvl_q) + AW'(1);
    rd2_a = AW'(lvl_q) + OFS_M;
  end

  assign busy_o = (state_q != ST_IDLE);

  // Sequencer with registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_q       <= '0;
      w0_q         <= '0;
      p0_q         <= '0;
      p1_q         <= '0;
      p2_q         <= '0;
      tmp_q        <= '0;
      idx_q        <= '0;
      lvl_q        <= '0;
      levels_q     <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      done_o       <= 1'b0;
      src_vertex_o <= '0;
      dst_vertex_o <= '0;
      edge_valid_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            prev_q   <= seed0;
            w0_q     <= seed0;
            idx_q    <= AW'(1);
            lvl_q    <= '0;
            src_q    <= '0;
            dst_q    <= '0;
            levels_q <= (scale_q > MAX_LV) ? MAX_LV : scale_q;
            state_q  <= ST_MUL;
          end
        end
        ST_MUL: begin
          p0_q    <= 64'(xw[31:0]) * 64'(rmat_pkg::TW_INIT_MUL[31:0]);
          p1_q    <= 32'(xw[63:32] * rmat_pkg::TW_INIT_MUL[31:0]);
          p2_q    <= 32'(xw[31:0] * rmat_pkg::TW_INIT_MUL[63:32]);
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          prev_q <= seed_w;
          idx_q  <= idx_q + AW'(1);
          if (idx_q == SEED_LAST) begin
            state_q <= (levels_q == 6'd0) ? ST_DONE : ST_RD;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_RD: state_q <= ST_TEMP;
        ST_TEMP: begin
          tmp_q   <= t4;
          w0_q    <= rd1_q;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          src_q <= {src_q[rmat_pkg::VTX_W-2:0], sb};
          dst_q <= {dst_q[rmat_pkg::VTX_W-2:0], db};
          lvl_q <= lvl_q + 6'd1;
          state_q <= (lvl_q + 6'd1 == levels_q) ? ST_DONE : ST_RD;
        end
        ST_DONE: begin
          done_o <= 1'b1;
          if (src_q == dst_q) begin
            src_vertex_o <= '0;
            dst_vertex_o <= '0;
            edge_valid_o <= 1'b0;
          end else begin
            src_vertex_o <= (src_q < dst_q) ? src_q : dst_q;
            dst_vertex_o <= (src_q < dst_q) ? dst_q : src_q;
            edge_valid_o <= 1'b1;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("item accepted but not busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && edge_valid_o |-> src_vertex_o < dst_vertex_o)
    else $error("endpoints not ordered");
  a_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !edge_valid_o |-> src_vertex_o == '0 && dst_vertex_o == '0)
    else $error("dropped edge not zeroed");
  a_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> lvl_q <= levels_q) else $error("level count overrun");

endmodule
